// ----- rtl/pcvr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcvr_pkg: shared types and constants for the per-class value rank block
// Word formats on the ports, the cell contents and the cell control bundle.
// ----------------------------------------------------------------------------
package pcvr_pkg;

  localparam int MAX_CELLS = 64;
  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int RANK_W    = $clog2(MAX_CELLS + 1);

  localparam int VALUE_W   = 32;
  localparam int CLASS_W   = 32;
  localparam int OIDX_W    = 6;
  localparam int ORANK_W   = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cell_value;
    logic                      value_missing;
    logic signed [CLASS_W-1:0] class_id;
    logic                      class_missing;
    logic                      last_cell;
  } in_word_t;

  typedef struct packed {
    logic [OIDX_W-1:0]  cell_index;
    logic [ORANK_W-1:0] rank;
    logic               rank_missing;
    logic               last_result;
  } out_word_t;

  // contents of one stored cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [CLASS_W-1:0] cls;
    logic                      vok;
    logic                      cok;
  } item_t;

  // entry travelling around the ring during ranking
  typedef struct packed {
    item_t            item;
    logic [IDX_W-1:0] idx;
  } circ_t;

  // rank result shifted toward cell 0 during output
  typedef struct packed {
    logic [RANK_W-1:0] count;
    logic              miss;
  } res_t;

  typedef struct packed {
    logic load;
    logic rank;
    logic shift;
    logic clear;
    logic by_class;
  } cell_ctl_t;

endpackage

// ----- rtl/per_class_value_rank.sv -----
// ----------------------------------------------------------------------------
// per_class_value_rank: rank of each cell by ascending value
// Collects a set of cells, ranks them globally or within their class on a
// ring of cells, then streams one rank word per cell in index order.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  input     start, busy, cell_word           taken when start && !busy
//  config    cfg_valid, cfg_ready, cfg_data   written when valid && ready
//  result    result_valid, result             one-cycle strobe, no stall
//
// Cells load one per cycle while busy is low. After the last cell the ring
// is seeded, then rotated (every entry passes every cell once), then one
// result word per stored cell, one per cycle. busy stays high from the last
// cell until the last result is registered. Sync reset clears the fill and
// all presence flags; the result side cannot stall, so output never waits.
module per_class_value_rank
  import pcvr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  cell_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  output logic      result_valid,
  output out_word_t result
);

  typedef enum logic [1:0] {S_FILL, S_LOAD, S_RANK, S_OUT} state_t;

  state_t           state;
  logic [CNT_W-1:0] fill_count;
  logic [IDX_W-1:0] rot_cnt;
  logic [IDX_W-1:0] out_idx;
  logic             mode;
  logic             mode_q;

  logic      accept;
  logic      store;
  logic      out_last;
  cell_ctl_t ctl;
  item_t     wr_item;

  circ_t circ_out [MAX_CELLS];
  res_t  res_out  [MAX_CELLS];
  res_t  res_in   [MAX_CELLS];
  logic  wr_en    [MAX_CELLS];

  assign busy      = (state != S_FILL);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign store     = accept && (fill_count < CNT_W'(MAX_CELLS));
  assign out_last  = (CNT_W'(out_idx) + CNT_W'(1)) == fill_count;

  assign wr_item.value = cell_word.cell_value;
  assign wr_item.cls   = cell_word.class_id;
  assign wr_item.vok   = !cell_word.value_missing;
  assign wr_item.cok   = !cell_word.class_missing;

  assign ctl.load     = (state == S_LOAD);
  assign ctl.rank     = (state == S_RANK);
  assign ctl.shift    = (state == S_OUT);
  assign ctl.clear    = (state == S_OUT) && out_last;
  assign ctl.by_class = mode_q;

  genvar k;
  generate
    for (k = 0; k < MAX_CELLS; k++) begin : g_cell
      assign wr_en[k]  = store && (fill_count[IDX_W-1:0] == IDX_W'(k));
      if (k == MAX_CELLS - 1) begin : g_end
        assign res_in[k] = '0;
      end else begin : g_mid
        assign res_in[k] = res_out[k+1];
      end

      pcvr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .cell_id  (IDX_W'(k)),
        .wr_en    (wr_en[k]),
        .wr_item  (wr_item),
        .circ_in  (circ_out[(k + 1) % MAX_CELLS]),
        .circ_out (circ_out[k]),
        .res_in   (res_in[k]),
        .res_out  (res_out[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      fill_count   <= '0;
      rot_cnt      <= '0;
      out_idx      <= '0;
      mode         <= 1'b0;
      mode_q       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      case (state)
        S_FILL: begin
          if (store) begin
            fill_count <= fill_count + CNT_W'(1);
          end
          if (accept && cell_word.last_cell) begin
            mode_q <= mode;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          rot_cnt <= '0;
          state   <= S_RANK;
        end
        S_RANK: begin
          if (rot_cnt == IDX_W'(MAX_CELLS - 1)) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            rot_cnt <= rot_cnt + IDX_W'(1);
          end
        end
        S_OUT: begin
          result_valid        <= 1'b1;
          result.cell_index   <= OIDX_W'(out_idx);
          result.rank         <= ORANK_W'(res_out[0].count);
          result.rank_missing <= res_out[0].miss;
          result.last_result  <= out_last;
          out_idx             <= out_idx + IDX_W'(1);
          if (out_last) begin
            fill_count <= '0;
            state      <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_CELLS))
    else $error("fill count beyond cell count");

  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cell_word.last_cell |=> state == S_LOAD)
    else $error("last cell did not start ranking");

  a_load_to_rank: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> state == S_RANK && rot_cnt == '0)
    else $error("ring rotation not restarted");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_OUT))
    else $error("result word outside output phase");

  a_last_clears_fill: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> fill_count == '0 && state == S_FILL)
    else $error("fill not cleared after last result");
`endif

endmodule

// ----- rtl/pcvr_cell.sv -----
// ----------------------------------------------------------------------------
// pcvr_cell: one cell of the ranking ring
// Holds one stored cell, compares it against the entry passing by and counts
// the entries that rank below it. Shifts its result toward cell 0 on output.
// ----------------------------------------------------------------------------
module pcvr_cell
  import pcvr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_id,
  input  logic             wr_en,
  input  item_t            wr_item,
  input  circ_t            circ_in,
  output circ_t            circ_out,
  input  res_t             res_in,
  output res_t             res_out
);

  logic signed [VALUE_W-1:0] home_value;
  logic signed [CLASS_W-1:0] home_cls;
  logic                      home_vok;
  logic                      home_cok;
  circ_t                     circ;
  res_t                      res;

  logic home_usable;
  logic circ_usable;
  logic same_class;
  logic below;
  logic hit;

  assign home_usable = home_vok && (!ctl.by_class || home_cok);
  assign circ_usable = circ.item.vok && (!ctl.by_class || circ.item.cok);
  assign same_class  = !ctl.by_class || (circ.item.cls == home_cls);
  // ties go to the lower index
  assign below       = ($signed(circ.item.value) < $signed(home_value)) ||
                       ((circ.item.value == home_value) && (circ.idx < cell_id));
  assign hit         = home_usable && circ_usable && same_class && below;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_vok <= 1'b0;
      home_cok <= 1'b0;
    end else if (ctl.clear) begin
      home_vok <= 1'b0;
      home_cok <= 1'b0;
    end else if (wr_en) begin
      home_vok <= wr_item.vok;
      home_cok <= wr_item.cok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      home_value <= wr_item.value;
      home_cls   <= wr_item.cls;
    end
    if (ctl.load) begin
      circ.item.value <= home_value;
      circ.item.cls   <= home_cls;
      circ.item.vok   <= home_vok;
      circ.item.cok   <= home_cok;
      circ.idx        <= cell_id;
      res.count       <= RANK_W'(home_usable);
      res.miss        <= !home_usable;
    end else if (ctl.rank) begin
      circ <= circ_in;
      if (hit) begin
        res.count <= res.count + RANK_W'(1);
      end
    end else if (ctl.shift) begin
      res <= res_in;
    end
  end

  assign circ_out = circ;
  assign res_out  = res;

endmodule

// ----- verif/per_class_value_rank_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_class_value_rank_checker: rank predictor and result check
// Watches the cell, config and result channels of the rank block. Keeps its
// own copy of the set being filled and of the mode, works out the rank word
// of every cell when the last cell is taken, and checks each result word
// against the oldest expected one.
// ----------------------------------------------------------------------------
module per_class_value_rank_checker
  import pcvr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  cell_word,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      result_valid,
  input  out_word_t result,
  output int        errors,
  output int        words_due
);

  logic signed [VALUE_W-1:0] held_value [MAX_CELLS];
  logic signed [CLASS_W-1:0] held_class [MAX_CELLS];
  logic                      value_ok   [MAX_CELLS];
  logic                      class_ok   [MAX_CELLS];
  int                        held       = 0;
  logic                      by_class   = 1'b0;
  out_word_t                 ranks_due [$];
  int                        mismatches = 0;

  function automatic logic ranked(int k);
    return value_ok[k] && (!by_class || class_ok[k]);
  endfunction

  // one rank word per held cell, then the set empties
  function automatic void rank_set();
    out_word_t w;
    int r;
    for (int i = 0; i < held; i++) begin
      r = 0;
      if (ranked(i)) begin
        r = 1;
        for (int j = 0; j < held; j++) begin
          if (j != i && ranked(j) && (!by_class || held_class[j] == held_class[i]) &&
              (held_value[j] < held_value[i] ||
               (held_value[j] == held_value[i] && j < i)))
            r++;
        end
      end
      w.cell_index   = OIDX_W'(i);
      w.rank         = ORANK_W'(r);
      w.rank_missing = !ranked(i);
      w.last_result  = (i == held - 1);
      ranks_due      = {ranks_due, w};
    end
    held = 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      held     = 0;
      by_class = 1'b0;
      ranks_due.delete();
    end else begin
      if (result_valid) begin
        if (ranks_due.size() == 0) begin
          $error("unexpected rank word for cell %0d", result.cell_index);
          mismatches++;
        end else begin
          want = ranks_due.pop_front();
          check_field("cell_index", 32'(want.cell_index), 32'(result.cell_index));
          check_field("rank", 32'(want.rank), 32'(result.rank));
          check_field("rank_missing", 32'(want.rank_missing), 32'(result.rank_missing));
          check_field("last_result", 32'(want.last_result), 32'(result.last_result));
        end
      end
      if (start && !busy) begin
        // a full set drops further cells, but a last cell still ends it
        if (held < MAX_CELLS) begin
          held_value[held] = cell_word.cell_value;
          held_class[held] = cell_word.class_id;
          value_ok[held]   = !cell_word.value_missing;
          class_ok[held]   = !cell_word.class_missing;
          held++;
        end
        if (cell_word.last_cell)
          rank_set();
      end
      if (cfg_valid && cfg_ready)
        by_class = cfg_data;
    end
    words_due <= ranks_due.size();
    errors    <= mismatches;
  end

endmodule

// ----- verif/per_class_value_rank_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_class_value_rank_test: testbench for the per-class value rank block
// Sends directed sets of cells for extremes, ties and missing flags in both
// modes, then random sets of mostly small size with a full and an overfull
// set, under varying sender idling and mode changes between sets.
// ----------------------------------------------------------------------------
module per_class_value_rank_test
  import pcvr_pkg::*;
;

  localparam int DRAIN       = 2 * MAX_CELLS + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int SMALL_ITEMS = 45;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      start     = 1'b0;
  logic      busy;
  in_word_t  cell_word = '0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;
  logic      result_valid;
  out_word_t result;
  int        errors;
  int        words_due;
  int        idle_pct  = 0;

  per_class_value_rank DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cell_word    (cell_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  per_class_value_rank_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cell_word    (cell_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result),
    .errors       (errors),
    .words_due    (words_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic in_word_t make_cell(logic [31:0] v, logic vm, logic [31:0] c,
                                         logic cm, logic last);
    in_word_t w;
    w.cell_value    = v;
    w.value_missing = vm;
    w.class_id      = c;
    w.class_missing = cm;
    w.last_cell     = last;
    return w;
  endfunction

  // small values and classes give ties and shared classes, the rest spread wide
  function automatic in_word_t random_cell(logic last);
    logic [31:0] edges [4];
    logic [31:0] v;
    logic [31:0] c;
    int unsigned pick;
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    pick = $urandom_range(9);
    if (pick < 4)      v = $urandom_range(6) - 3;
    else if (pick < 6) v = edges[2'($urandom_range(3))];
    else               v = $urandom;
    pick = $urandom_range(9);
    if (pick < 6)      c = $urandom_range(2);
    else if (pick < 7) c = edges[2'($urandom_range(3))];
    else               c = $urandom;
    return make_cell(v, $urandom_range(9) == 0, c, $urandom_range(9) == 0, last);
  endfunction

  task automatic send_cell(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    cell_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_set(int n);
    for (int k = 0; k < n; k++)
      send_cell(random_cell(k == n - 1));
  endtask

  // wait for every expected rank word, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_due != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // global ranks: extremes, a tie, a missing value, class flags ignored
    send_cell(make_cell(32'h7fff_ffff, 1'b0, 32'd7, 1'b0, 1'b0));
    send_cell(make_cell(32'h8000_0000, 1'b0, 32'd7, 1'b0, 1'b0));
    send_cell(make_cell(32'h0000_0000, 1'b0, 32'd1, 1'b0, 1'b0));
    send_cell(make_cell(32'hffff_ffff, 1'b0, 32'd2, 1'b0, 1'b0));
    send_cell(make_cell(32'h0000_0000, 1'b0, 32'd3, 1'b0, 1'b0));
    send_cell(make_cell(32'h0000_0000, 1'b1, 32'd3, 1'b0, 1'b0));
    send_cell(make_cell(32'h0001_0000, 1'b0, 32'd3, 1'b1, 1'b1));
    send_cell(make_cell(32'hfffb_0000, 1'b0, 32'd0, 1'b0, 1'b1));
    send_cell(make_cell(32'h0000_0005, 1'b1, 32'd0, 1'b0, 1'b1));

    // per-class ranks: extreme classes, tie within a class, missing class
    write_mode(1'b1);
    send_cell(make_cell(32'd3, 1'b0, 32'h8000_0000, 1'b0, 1'b0));
    send_cell(make_cell(32'd3, 1'b0, 32'h7fff_ffff, 1'b0, 1'b0));
    send_cell(make_cell(32'hffff_fffe, 1'b0, 32'h8000_0000, 1'b0, 1'b0));
    send_cell(make_cell(32'd3, 1'b0, 32'h8000_0000, 1'b0, 1'b0));
    send_cell(make_cell(32'd1, 1'b0, 32'h7fff_ffff, 1'b1, 1'b0));
    send_cell(make_cell(32'd9, 1'b1, 32'd0, 1'b0, 1'b0));
    send_cell(make_cell(32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
    send_cell(make_cell(32'h8000_0000, 1'b0, 32'h7fff_ffff, 1'b0, 1'b0));
    send_cell(make_cell(32'h7fff_ffff, 1'b0, 32'h8000_0000, 1'b0, 1'b1));
    send_cell(make_cell(32'd4, 1'b0, 32'd5, 1'b1, 1'b1));

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 81 : 36;
      write_mode(p != 0);
      // a full set, and one that overflows with its last cell dropped
      if (p == 0)
        send_random_set(MAX_CELLS);
      else if (p == 2)
        send_random_set(MAX_CELLS + 2);
      sent = 0;
      while (sent < SMALL_ITEMS) begin
        if ($urandom_range(9) < 3)
          write_mode(1'($urandom_range(1)));
        n = $urandom_range(1, 10);
        send_random_set(n);
        sent += n;
      end
    end

    drain();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcvr_pkg.sv
rtl/pcvr_cell.sv
rtl/per_class_value_rank.sv
verif/per_class_value_rank_checker.sv
verif/per_class_value_rank_test.sv
